// ===== rtl/cta_pkg.sv =====
package cta_pkg;

  // Field widths of one time stamp.
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned OffW   = 6;

  // Calendar constants.
  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned DaysPerWeek   = 7;
  localparam int unsigned YearWrap      = 10000;
  localparam int unsigned MaxOffset     = 23;

  // Days in a month; any code outside 1..12 counts as a long month.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cta_utc_if.sv =====
interface cta_utc_if
  import cta_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HourW-1:0]  utc_hour;
  logic [DayW-1:0]   utc_day;
  logic [MonthW-1:0] utc_month;
  logic [YearW-1:0]  utc_year;
  logic [WdayW-1:0]  utc_weekday;

  modport source (output valid, utc_hour, utc_day, utc_month, utc_year, utc_weekday,
                  input ready);
  modport sink   (input valid, utc_hour, utc_day, utc_month, utc_year, utc_weekday,
                  output ready);
endinterface

// ===== rtl/cta_local_if.sv =====
interface cta_local_if
  import cta_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HourW-1:0]  local_hour;
  logic [DayW-1:0]   local_day;
  logic [MonthW-1:0] local_month;
  logic [YearW-1:0]  local_year;
  logic [WdayW-1:0]  local_weekday;

  modport source (output valid, local_hour, local_day, local_month, local_year,
                  local_weekday, input ready);
  modport sink   (input valid, local_hour, local_day, local_month, local_year,
                  local_weekday, output ready);
endinterface

// ===== rtl/calendar_timezone_adjust.sv =====
// Shifts a UTC time stamp by a signed whole-hour offset (written through cfg_we_i and
// cfg_wdata_i, saturated to -23..23) and returns the local time stamp, stepping the
// date by at most one day with Gregorian month lengths and year wrap at 10000. The
// block is a three-stage pipeline: it accepts one word per cycle while the output
// side does not stall, and each word is registered in stages A, B and C. A stall at the
// output holds all three stages, so utc_i.ready follows local_o.ready whenever the
// output stage is full. An offset of zero passes every field through unchanged.
module calendar_timezone_adjust
  import cta_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic signed [OffW-1:0] cfg_wdata_i,
  cta_utc_if.sink               utc_i,
  cta_local_if.source           local_o
);

  // Reciprocal of 25 scaled by 2^19; exact quotient for every 14-bit year.
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = YearW + 15;
  localparam int unsigned QuotW      = ProdW - RecipShift;
  localparam logic [ProdW-1:0] Recip25 = ProdW'(20972);

  typedef struct packed {
    logic               off_nz;
    logic signed [6:0]  adj;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [YearW-1:0]   year_m;
    logic [WdayW-1:0]   wday;
    logic [QuotW-1:0]   quot25;
  } stage_a_t;

  typedef struct packed {
    logic               back;
    logic               fwd;
    logic               borrow;
    logic               carry;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [MonthW-1:0]  month_prev;
    logic [DayW-1:0]    len_prev;
    logic [YearW-1:0]   year;
    logic [YearW-1:0]   year_dec;
    logic [YearW-1:0]   year_inc;
    logic [WdayW-1:0]   wday;
  } stage_b_t;

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [WdayW-1:0]   wday;
  } stage_c_t;

  logic signed [OffW-1:0] offset_q;
  logic                   a_valid_q, b_valid_q, c_valid_q;
  stage_a_t               a_d, a_q;
  stage_b_t               b_d, b_q;
  stage_c_t               c_d, c_q;
  logic                   adv;

  // The whole pipeline moves when the output stage is empty or being drained.
  assign adv         = !c_valid_q || local_o.ready;
  assign utc_i.ready = adv;

  // Offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Stage A: saturate offset, clamp hour, add, and start the year divide by 25.
  always_comb begin
    logic signed [OffW-1:0] off_sat;
    logic [HourW-1:0]       hour_c;
    logic [ProdW-1:0]       prod;
    if (offset_q > $signed(OffW'(MaxOffset))) begin
      off_sat = $signed(OffW'(MaxOffset));
    end else if (offset_q < -$signed(OffW'(MaxOffset))) begin
      off_sat = -$signed(OffW'(MaxOffset));
    end else begin
      off_sat = offset_q;
    end
    hour_c = (utc_i.utc_hour > HourW'(HoursPerDay - 1)) ? HourW'(HoursPerDay - 1)
                                                         : utc_i.utc_hour;
    prod   = ProdW'(utc_i.utc_year) * Recip25;

    a_d.off_nz = (offset_q != '0);
    a_d.adj    = $signed({2'b00, hour_c}) + $signed({off_sat[OffW-1], off_sat});
    a_d.hour   = utc_i.utc_hour;
    a_d.day    = utc_i.utc_day;
    a_d.month  = utc_i.utc_month;
    a_d.year   = utc_i.utc_year;
    a_d.year_m = (utc_i.utc_year >= YearW'(YearWrap)) ? utc_i.utc_year - YearW'(YearWrap)
                                                      : utc_i.utc_year;
    a_d.wday   = utc_i.utc_weekday;
    a_d.quot25 = prod[ProdW-1:RecipShift];
  end

  // Stage B: leap test, step direction, wrapped hour, month lengths and year neighbors.
  always_comb begin
    logic [YearW-1:0] times25;
    logic             div25;
    logic             leap;
    logic [DayW-1:0]  len_cur;
    times25 = {a_q.quot25, 4'b0000} + {1'b0, a_q.quot25, 3'b000} + {4'b0000, a_q.quot25};
    div25   = (times25 == a_q.year);
    leap    = (a_q.year[1:0] == 2'b00) && (!div25 || (a_q.year[3:0] == 4'b0000));
    len_cur = month_len(a_q.month, leap);

    b_d.back   = a_q.off_nz && a_q.adj[6];
    b_d.fwd    = a_q.off_nz && !a_q.adj[6] && (a_q.adj >= 7'sd24);
    b_d.borrow = (a_q.day <= DayW'(1));
    b_d.carry  = ({1'b0, a_q.day} + 6'd1) > {1'b0, len_cur};
    if (!a_q.off_nz) begin
      b_d.hour = a_q.hour;
    end else if (a_q.adj[6]) begin
      b_d.hour = HourW'(a_q.adj + 7'sd24);
    end else if (a_q.adj >= 7'sd24) begin
      b_d.hour = HourW'(a_q.adj - 7'sd24);
    end else begin
      b_d.hour = a_q.adj[HourW-1:0];
    end
    b_d.month_prev = (a_q.month <= MonthW'(1)) ? MonthW'(MonthsPerYear)
                                               : a_q.month - MonthW'(1);
    b_d.len_prev   = month_len(b_d.month_prev, leap);
    b_d.day        = a_q.day;
    b_d.month      = a_q.month;
    b_d.year       = a_q.year;
    b_d.year_dec   = (a_q.year_m == '0) ? YearW'(YearWrap - 1) : a_q.year_m - YearW'(1);
    b_d.year_inc   = (a_q.year_m == YearW'(YearWrap - 1)) ? '0 : a_q.year_m + YearW'(1);
    b_d.wday       = a_q.wday;
  end

  // Stage C: pick the stepped date.
  always_comb begin
    c_d.hour  = b_q.hour;
    c_d.day   = b_q.day;
    c_d.month = b_q.month;
    c_d.year  = b_q.year;
    c_d.wday  = b_q.wday;
    if (b_q.back) begin
      if (b_q.borrow) begin
        c_d.month = b_q.month_prev;
        c_d.day   = b_q.len_prev;
        if (b_q.month <= MonthW'(1)) begin
          c_d.year = b_q.year_dec;
        end
      end else begin
        c_d.day = b_q.day - DayW'(1);
      end
      c_d.wday = (b_q.wday == '0) ? WdayW'(DaysPerWeek - 1) : b_q.wday - WdayW'(1);
    end else if (b_q.fwd) begin
      if (b_q.carry) begin
        c_d.day = DayW'(1);
        if (b_q.month >= MonthW'(MonthsPerYear)) begin
          c_d.month = MonthW'(1);
          c_d.year  = b_q.year_inc;
        end else begin
          c_d.month = b_q.month + MonthW'(1);
        end
      end else begin
        c_d.day = b_q.day + DayW'(1);
      end
      if (b_q.wday == WdayW'(DaysPerWeek - 1)) begin
        c_d.wday = '0;
      end else if (b_q.wday == WdayW'(DaysPerWeek)) begin
        c_d.wday = WdayW'(1);
      end else begin
        c_d.wday = b_q.wday + WdayW'(1);
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= utc_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  assign local_o.valid         = c_valid_q;
  assign local_o.local_hour    = c_q.hour;
  assign local_o.local_day     = c_q.day;
  assign local_o.local_month   = c_q.month;
  assign local_o.local_year    = c_q.year;
  assign local_o.local_weekday = c_q.wday;

endmodule

// ===== rtl/cta_checker.sv =====
module cta_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic       in_acc, out_acc;
  logic [2:0] inflight_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Count of words taken but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // Input side stalls only when the output stage is full and held.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow the output stage");

  // Three stages hold at most three words.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more words in flight than pipeline stages");

  // A word shown at the output was taken at the input.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 3'd0)
    else $error("output word without an accepted input word");

  // A stalled output word stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

endmodule

bind calendar_timezone_adjust cta_checker u_cta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (utc_i.valid),
  .in_ready_i  (utc_i.ready),
  .out_valid_i (local_o.valid),
  .out_ready_i (local_o.ready)
);

// ===== dv/testbench.sv =====
module testbench
  import cta_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One time stamp, UTC or local, at the widths of the ports.
  typedef struct packed {
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [WdayW-1:0]  wday;
  } stamp_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic signed [OffW-1:0] cfg_wdata_i;

  cta_utc_if   utc_bus ();
  cta_local_if local_bus ();

  calendar_timezone_adjust uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .utc_i       (utc_bus),
    .local_o     (local_bus)
  );

  // Words waiting to be driven and local stamps waiting to come out.
  stamp_t                 pending_utc[$];
  stamp_t                 expected_local[$];
  stamp_t                 drive_word;
  logic signed [OffW-1:0] tz_offset;
  int unsigned            src_idle_pct;
  int unsigned            snk_stall_pct;
  int unsigned            mismatch_count;
  int unsigned            words_sent;
  int unsigned            words_checked;
  int unsigned            offsets_written;

  // Offsets used by the first random phases: range ends, saturating codes, zero and one.
  logic signed [OffW-1:0] edge_offsets[8] = '{6'sd23, -6'sd23, 6'sd31, -6'sd32,
                                              6'sd24, -6'sd24, 6'sd0, 6'sd1};
  int unsigned            leap_years[8] = '{0, 9999, 1900, 2000, 2024, 2023, 2100, 2400};

  always #5 clk_i = ~clk_i;

  // Gregorian month length; codes outside 1..12 count as long months.
  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return leap ? 29 : 28;
    return 31;
  endfunction

  // Local stamp for one UTC stamp under the given raw offset code.
  function automatic stamp_t shift_stamp(stamp_t utc, logic signed [OffW-1:0] off_code);
    stamp_t      loc;
    int          off;
    int          adj;
    int unsigned hr;
    int unsigned dy;
    int unsigned mo;
    int unsigned yr;
    int unsigned wd;
    loc = utc;
    off = int'(off_code);
    if (off == 0) return loc;
    if (off > 23) off = 23;
    if (off < -23) off = -23;
    hr = (utc.hour > 5'd23) ? 32'd23 : 32'(utc.hour);
    dy = 32'(utc.day);
    mo = 32'(utc.month);
    yr = 32'(utc.year);
    wd = 32'(utc.wday);
    adj = int'(hr) + off;
    if (adj < 0) begin
      // Step back one day, borrowing from the month and the year.
      hr = adj + 24;
      if (dy <= 1) begin
        if (mo <= 1) begin
          mo = 12;
          yr = (yr % 10000 == 0) ? 9999 : (yr % 10000) - 1;
        end else begin
          mo = mo - 1;
        end
        dy = month_days(mo, yr);
      end else begin
        dy = dy - 1;
      end
      wd = (wd == 0) ? 6 : wd - 1;
    end else if (adj >= 24) begin
      // Step forward one day, carrying into the month and the year.
      hr = adj - 24;
      if (dy + 1 > month_days(mo, yr)) begin
        dy = 1;
        mo = mo + 1;
        if (mo > 12) begin
          mo = 1;
          yr = (yr % 10000 + 1) % 10000;
        end
      end else begin
        dy = dy + 1;
      end
      wd = (wd + 1) % 7;
    end else begin
      hr = adj;
    end
    loc.hour  = hr[HourW-1:0];
    loc.day   = dy[DayW-1:0];
    loc.month = mo[MonthW-1:0];
    loc.year  = yr[YearW-1:0];
    loc.wday  = wd[WdayW-1:0];
    return loc;
  endfunction

  function automatic stamp_t make_stamp(int unsigned h, int unsigned d, int unsigned m,
                                        int unsigned y, int unsigned w);
    stamp_t s;
    s.hour  = h[HourW-1:0];
    s.day   = d[DayW-1:0];
    s.month = m[MonthW-1:0];
    s.year  = y[YearW-1:0];
    s.wday  = w[WdayW-1:0];
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Wait until every word is accepted and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_utc.size() != 0 || utc_bus.valid || expected_local.size() != 0);
  endtask

  task automatic write_offset(logic signed [OffW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    tz_offset = value;
    offsets_written++;
  endtask

  // Mostly valid dates biased to month and day edges, with some raw noise.
  task automatic push_random(int unsigned count);
    stamp_t      s;
    logic [31:0] noise;
    int unsigned m;
    int unsigned y;
    int unsigned len;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 12) begin
        noise = $urandom;
        s = noise[$bits(stamp_t)-1:0];
      end else begin
        m = $urandom_range(12, 1);
        y = ($urandom_range(99) < 30) ? leap_years[$urandom_range(7)] : $urandom_range(9999);
        len = month_days(m, y);
        pick = $urandom_range(99);
        s.month = m[MonthW-1:0];
        s.year  = y[YearW-1:0];
        if (pick < 40) s.day = DayW'(1);
        else if (pick < 80) s.day = len[DayW-1:0];
        else s.day = DayW'($urandom_range(len, 1));
        pick = $urandom_range(99);
        if (pick < 25) s.hour = HourW'($urandom_range(2));
        else if (pick < 50) s.hour = HourW'($urandom_range(23, 21));
        else s.hour = HourW'($urandom_range(23));
        s.wday = WdayW'($urandom_range(6));
      end
      pending_utc.push_back(s);
    end
  endtask

  // Driver: present the next pending word, holding it until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      utc_bus.valid <= 1'b0;
    end else if (!utc_bus.valid || utc_bus.ready) begin
      if (pending_utc.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_word = pending_utc.pop_front();
        utc_bus.valid       <= 1'b1;
        utc_bus.utc_hour    <= drive_word.hour;
        utc_bus.utc_day     <= drive_word.day;
        utc_bus.utc_month   <= drive_word.month;
        utc_bus.utc_year    <= drive_word.year;
        utc_bus.utc_weekday <= drive_word.wday;
      end else begin
        utc_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure on the local side.
  always @(posedge clk_i) begin
    local_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Monitor: predict on every accepted UTC word, check every local word.
  always @(posedge clk_i) begin
    stamp_t in_word;
    stamp_t got;
    stamp_t want;
    if (rst_ni) begin
      if (utc_bus.valid && utc_bus.ready) begin
        in_word = {utc_bus.utc_hour, utc_bus.utc_day, utc_bus.utc_month,
                   utc_bus.utc_year, utc_bus.utc_weekday};
        expected_local.push_back(shift_stamp(in_word, tz_offset));
        words_sent++;
      end
      if (local_bus.valid && local_bus.ready) begin
        got = {local_bus.local_hour, local_bus.local_day, local_bus.local_month,
               local_bus.local_year, local_bus.local_weekday};
        if (expected_local.size() == 0) begin
          report_mismatch($sformatf("unexpected local word %0d/%0d/%0d %0d h wd %0d",
                                    got.year, got.month, got.day, got.hour, got.wday));
        end else begin
          want = expected_local.pop_front();
          if (got.hour !== want.hour)
            report_mismatch($sformatf("word %0d hour %0d, want %0d",
                                      words_checked, got.hour, want.hour));
          if (got.day !== want.day)
            report_mismatch($sformatf("word %0d day %0d, want %0d",
                                      words_checked, got.day, want.day));
          if (got.month !== want.month)
            report_mismatch($sformatf("word %0d month %0d, want %0d",
                                      words_checked, got.month, want.month));
          if (got.year !== want.year)
            report_mismatch($sformatf("word %0d year %0d, want %0d",
                                      words_checked, got.year, want.year));
          if (got.wday !== want.wday)
            report_mismatch($sformatf("word %0d weekday %0d, want %0d",
                                      words_checked, got.wday, want.wday));
          words_checked++;
        end
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    utc_bus.valid       = 1'b0;
    utc_bus.utc_hour    = '0;
    utc_bus.utc_day     = '0;
    utc_bus.utc_month   = '0;
    utc_bus.utc_year    = '0;
    utc_bus.utc_weekday = '0;
    local_bus.ready     = 1'b0;
    tz_offset           = '0;
    src_idle_pct        = 0;
    snk_stall_pct       = 0;
    mismatch_count      = 0;
    words_sent          = 0;
    words_checked       = 0;
    offsets_written     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero offset after reset passes even out-of-range fields through.
    pending_utc.push_back(make_stamp(31, 0, 15, 16383, 7));
    pending_utc.push_back(make_stamp(0, 1, 1, 0, 0));
    pending_utc.push_back(make_stamp(23, 31, 12, 9999, 6));
    wait_drained();

    // One hour back: year, leap and month borrows, weekday wrap.
    write_offset(-6'sd1);
    pending_utc.push_back(make_stamp(0, 1, 1, 0, 0));
    pending_utc.push_back(make_stamp(0, 1, 3, 2000, 3));
    pending_utc.push_back(make_stamp(0, 1, 3, 1900, 4));
    pending_utc.push_back(make_stamp(0, 1, 3, 2023, 5));
    pending_utc.push_back(make_stamp(0, 0, 5, 2024, 7));
    pending_utc.push_back(make_stamp(0, 9, 0, 12000, 2));
    pending_utc.push_back(make_stamp(0, 5, 15, 16383, 1));
    pending_utc.push_back(make_stamp(31, 1, 1, 10000, 0));
    pending_utc.push_back(make_stamp(5, 31, 12, 16000, 6));
    wait_drained();

    // One hour forward: month and year carries, leap February, clamped hour.
    write_offset(6'sd1);
    pending_utc.push_back(make_stamp(23, 31, 12, 9999, 6));
    pending_utc.push_back(make_stamp(23, 28, 2, 2023, 0));
    pending_utc.push_back(make_stamp(23, 28, 2, 2024, 1));
    pending_utc.push_back(make_stamp(23, 29, 2, 2000, 2));
    pending_utc.push_back(make_stamp(31, 30, 4, 2100, 7));
    pending_utc.push_back(make_stamp(23, 31, 13, 16383, 3));
    pending_utc.push_back(make_stamp(23, 5, 15, 12345, 5));
    pending_utc.push_back(make_stamp(23, 31, 1, 0, 6));
    pending_utc.push_back(make_stamp(10, 31, 0, 0, 4));
    wait_drained();

    // Random phases, cycling through the idling modes and many offsets.
    for (int unsigned p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 85;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 85;
        end
        default: begin
          src_idle_pct  = 31;
          snk_stall_pct = 31;
        end
      endcase
      if (p < 8) write_offset(edge_offsets[p]);
      else write_offset(OffW'($urandom_range(63)));
      if (p == 6) begin
        // The sender holds off until the pipeline has emptied.
        push_random(25);
        wait_drained();
        push_random(25);
      end else begin
        push_random(50);
      end
      wait_drained();
    end

    // Let the pipeline settle, then look for anything left over.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (expected_local.size() != 0)
      report_mismatch($sformatf("%0d local words never arrived", expected_local.size()));
    $display("Sent %0d UTC words under %0d offset settings and checked %0d local words,",
             words_sent, offsets_written, words_checked);
    $display("with date carries, leap years, saturation and stalls on both sides.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout: %0d words still expected", expected_local.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
